// ===== design/twqa_pkg.sv =====
`timescale 1ns / 1ps

package twqa_pkg;

  // Field widths of one packet header.
  localparam int unsigned ChipW = 8;
  localparam int unsigned ChanW = 5;
  localparam int unsigned WinW = 16;
  localparam int unsigned CntW = 10;
  localparam int unsigned QIdxOutW = 6;

  // Stream widths, padded to whole bytes.
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 48;

  // Default configuration of the queue array.
  localparam int unsigned DefChannelsPerChip = 32;
  localparam int unsigned DefChipCount = 2;
  localparam int unsigned DefQueueDepth = 8;

  // Input item kinds carried on tuser.
  localparam logic OpPush = 1'b0;
  localparam logic OpTick = 1'b1;

  // One stored packet header; the chip number sits in the lowest bits.
  typedef struct packed {
    logic [CntW-1:0]  samples;
    logic [WinW-1:0]  window;
    logic [ChanW-1:0] channel;
    logic [ChipW-1:0] chip;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);
  localparam int unsigned OutPadW = OutDataW - EntryW - QIdxOutW - 1;

endpackage

// ===== design/twqa_ram.sv =====
`timescale 1ns / 1ps

module twqa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/twqa_qmap.sv =====
`timescale 1ns / 1ps

module twqa_qmap #(
  parameter int unsigned CHANNELS_PER_CHIP = twqa_pkg::DefChannelsPerChip,
  parameter int unsigned CHIP_COUNT = twqa_pkg::DefChipCount,
  localparam int unsigned QueueCount = CHANNELS_PER_CHIP * CHIP_COUNT,
  localparam int unsigned QIdxW = (QueueCount > 1) ? $clog2(QueueCount) : 1
) (
  input  logic [twqa_pkg::ChipW-1:0] chip_i,
  input  logic [twqa_pkg::ChanW-1:0] chan_i,
  output logic [QIdxW-1:0]           queue_o
);

  import twqa_pkg::*;

  localparam int unsigned ChanValues = 2 ** ChanW;
  localparam int unsigned ChipValues = 2 ** ChipW;

  typedef logic [5:0] chip_tab_t [ChipValues];
  typedef logic [5:0] quot_tab_t [ChanValues];
  typedef logic [ChanW-1:0] rem_tab_t [ChanValues];

  // The tables are built by counting, so no division is needed.
  function automatic chip_tab_t build_chip_tab();
    chip_tab_t   tab;
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < ChipValues; i++) begin
      tab[i] = 6'(r);
      r = (r + 1 == CHIP_COUNT) ? 0 : r + 1;
    end
    return tab;
  endfunction

  function automatic quot_tab_t build_quot_tab();
    quot_tab_t   tab;
    int unsigned a;
    int unsigned b;
    a = 0;
    b = 0;
    for (int unsigned i = 0; i < ChanValues; i++) begin
      tab[i] = 6'(a);
      b = b + 1;
      if (b == CHANNELS_PER_CHIP) begin
        b = 0;
        a = (a + 1 == CHIP_COUNT) ? 0 : a + 1;
      end
    end
    return tab;
  endfunction

  function automatic rem_tab_t build_rem_tab();
    rem_tab_t    tab;
    int unsigned b;
    b = 0;
    for (int unsigned i = 0; i < ChanValues; i++) begin
      tab[i] = ChanW'(b);
      b = (b + 1 == CHANNELS_PER_CHIP) ? 0 : b + 1;
    end
    return tab;
  endfunction

  localparam chip_tab_t ChipTab = build_chip_tab();
  localparam quot_tab_t QuotTab = build_quot_tab();
  localparam rem_tab_t  RemTab = build_rem_tab();

  logic [6:0]  chip_sum;
  logic [6:0]  chip_mod;
  logic [11:0] flat_idx;

  // Both table values are below the chip count, so one subtraction wraps the sum.
  assign chip_sum = {1'b0, ChipTab[chip_i]} + {1'b0, QuotTab[chan_i]};
  assign chip_mod = (chip_sum >= 7'(CHIP_COUNT)) ? chip_sum - 7'(CHIP_COUNT) : chip_sum;
  assign flat_idx = 12'(chip_mod) * 12'(CHANNELS_PER_CHIP) + 12'(RemTab[chan_i]);
  assign queue_o  = QIdxW'(flat_idx);

endmodule

// ===== design/time_window_queue_aligner_unit.sv =====
`timescale 1ns / 1ps

// Time-window queue aligner. Each push item sorts one packet header into the queue at
// index (chip * CHANNELS_PER_CHIP + channel) mod queue count; a push into a full queue
// is dropped and sets a sticky overflow flag that rides on every dispatched item. A tick
// item walks all queue heads; when every queue holds a head of the current time window,
// one packet is popped from each queue in index order and sent out, the final one
// marked with tlast, and the window counter advances (wrapping at 16 bits). Otherwise
// the tick sends nothing and changes nothing, so a head from another window holds the
// block until reset. Items are taken one at a time: a push goes through accept, metadata
// read and write. A tick goes through the accept and the first metadata read, then a
// check walk over the queues (store read, window compare) and a dispatch walk (pop,
// output load), which waits while the output is stalled; a failed check ends at the
// first bad queue. Both walks are paced by the registered reads of the metadata
// memory followed by the packet store for each queue head. After reset a clearing pass
// over every queue zeroes the per-queue metadata before the first item is accepted.
module time_window_queue_aligner_unit #(
  parameter int unsigned CHANNELS_PER_CHIP = twqa_pkg::DefChannelsPerChip,
  parameter int unsigned CHIP_COUNT = twqa_pkg::DefChipCount,
  parameter int unsigned QUEUE_DEPTH = twqa_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata from bit 0 up: chip_id[8], channel_id[5], window_tag[16], sample_count[10],
  // one zero pad bit.
  input  logic [twqa_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: opcode (0 push, 1 tick).
  input  logic                          s_axis_tuser_i,
  // Output stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata from bit 0 up: out_chip_id[8], out_channel_id[5], out_window_tag[16],
  // out_sample_count[10], queue_index[6], overflow_seen[1], two zero pad bits.
  output logic [twqa_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tlast: is_last, set on the final item of a dispatched window.
  output logic                          m_axis_tlast_o
);

  import twqa_pkg::*;

  localparam int unsigned QueueCount = CHANNELS_PER_CHIP * CHIP_COUNT;
  localparam int unsigned QIdxW = (QueueCount > 1) ? $clog2(QueueCount) : 1;
  localparam int unsigned HeadW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MetaW = FillW + HeadW;
  localparam int unsigned StoreDepth = QueueCount * QUEUE_DEPTH;
  localparam int unsigned StoreAW = $clog2(StoreDepth);

  // Sequencer states.
  localparam logic [3:0] StClear   = 4'd0;
  localparam logic [3:0] StIdle    = 4'd1;
  localparam logic [3:0] StPushRd  = 4'd2;
  localparam logic [3:0] StPushWr  = 4'd3;
  localparam logic [3:0] StChkRd   = 4'd4;
  localparam logic [3:0] StChkSt   = 4'd5;
  localparam logic [3:0] StChkCmp  = 4'd6;
  localparam logic [3:0] StEmitSt  = 4'd7;
  localparam logic [3:0] StEmitOut = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [QIdxW-1:0]   wq_q, wq_d;            // walk index, also the clearing counter
  logic [StoreAW-1:0] base_q, base_d;        // store base address of the walked queue
  logic [QIdxW-1:0]   pq_q, pq_d;            // queue of the pending push
  logic [StoreAW-1:0] push_base_q, push_base_d;
  entry_t             entry_q, entry_d;
  logic [WinW-1:0]    cur_win_q, cur_win_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // Memory ports.
  logic               meta_we, meta_re;
  logic [QIdxW-1:0]   meta_waddr, meta_raddr;
  logic [MetaW-1:0]   meta_wdata, meta_rdata;
  logic               st_we, st_re;
  logic [StoreAW-1:0] st_waddr, st_raddr;
  entry_t             st_rdata;

  logic [QIdxW-1:0]   push_queue;
  logic [FillW-1:0]   meta_fill;
  logic [HeadW-1:0]   meta_head;
  logic [HeadW-1:0]   head_inc;
  logic [HeadW:0]     pos_sum;
  logic [HeadW-1:0]   push_pos;
  logic               queue_full;
  logic               wq_last;
  logic [QIdxW-1:0]   wq_nxt;
  logic [StoreAW-1:0] base_nxt;
  logic [QIdxW+QIdxOutW-1:0] qidx_ext;
  logic               out_free;

  twqa_qmap #(
    .CHANNELS_PER_CHIP(CHANNELS_PER_CHIP),
    .CHIP_COUNT       (CHIP_COUNT)
  ) u_qmap (
    .chip_i (s_axis_tdata_i[ChipW-1:0]),
    .chan_i (s_axis_tdata_i[ChipW+ChanW-1:ChipW]),
    .queue_o(push_queue)
  );

  // Per-queue metadata: fill count above the head position.
  twqa_ram #(
    .WIDTH(MetaW),
    .DEPTH(QueueCount)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .re_i   (meta_re),
    .raddr_i(meta_raddr),
    .rdata_o(meta_rdata)
  );

  // Packet store: QUEUE_DEPTH consecutive entries per queue, used as a ring.
  twqa_ram #(
    .WIDTH(EntryW),
    .DEPTH(StoreDepth)
  ) u_store_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(entry_q),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  assign meta_fill = meta_rdata[MetaW-1:HeadW];
  assign meta_head = meta_rdata[HeadW-1:0];
  assign head_inc  = (meta_head == HeadW'(QUEUE_DEPTH - 1)) ? '0 : meta_head + HeadW'(1);

  // Tail position of a push; head and fill are both below the depth here.
  assign pos_sum   = {1'b0, meta_head} + (HeadW + 1)'(meta_fill);
  assign push_pos  = (pos_sum >= (HeadW + 1)'(QUEUE_DEPTH)) ?
                     HeadW'(pos_sum - (HeadW + 1)'(QUEUE_DEPTH)) : HeadW'(pos_sum);
  assign queue_full = (meta_fill == FillW'(QUEUE_DEPTH));

  assign wq_last  = (wq_q == QIdxW'(QueueCount - 1));
  assign wq_nxt   = wq_q + QIdxW'(1);
  assign base_nxt = base_q + StoreAW'(QUEUE_DEPTH);
  assign qidx_ext = {{QIdxOutW{1'b0}}, wq_q};
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign st_waddr = push_base_q + StoreAW'(push_pos);
  assign st_raddr = base_q + StoreAW'(meta_head);

  assign s_axis_tready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    wq_d        = wq_q;
    base_d      = base_q;
    pq_d        = pq_q;
    push_base_d = push_base_q;
    entry_d     = entry_q;
    cur_win_d   = cur_win_q;
    ovf_d       = ovf_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    meta_we     = 1'b0;
    meta_waddr  = wq_q;
    meta_wdata  = '0;
    meta_re     = 1'b0;
    meta_raddr  = wq_q;
    st_we       = 1'b0;
    st_re       = 1'b0;

    case (state_q)
      StClear: begin
        meta_we = 1'b1;
        if (wq_last) begin
          wq_d    = '0;
          state_d = StIdle;
        end else begin
          wq_d = wq_nxt;
        end
      end
      StIdle: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == OpPush) begin
            entry_d = entry_t'(s_axis_tdata_i[EntryW-1:0]);
            pq_d    = push_queue;
            state_d = StPushRd;
          end else begin
            wq_d    = '0;
            base_d  = '0;
            state_d = StChkRd;
          end
        end
      end
      StPushRd: begin
        meta_re     = 1'b1;
        meta_raddr  = pq_q;
        push_base_d = StoreAW'(pq_q * QUEUE_DEPTH);
        state_d     = StPushWr;
      end
      StPushWr: begin
        if (queue_full) begin
          ovf_d = 1'b1;
        end else begin
          st_we      = 1'b1;
          meta_we    = 1'b1;
          meta_waddr = pq_q;
          meta_wdata = {meta_fill + FillW'(1), meta_head};
        end
        state_d = StIdle;
      end
      StChkRd: begin
        meta_re = 1'b1;
        state_d = StChkSt;
      end
      StChkSt: begin
        if (meta_fill == '0) begin
          state_d = StIdle;
        end else begin
          st_re   = 1'b1;
          state_d = StChkCmp;
        end
      end
      StChkCmp: begin
        if (st_rdata.window != cur_win_q) begin
          state_d = StIdle;
        end else if (wq_last) begin
          // Every head matches: start the dispatch walk at queue zero.
          wq_d       = '0;
          base_d     = '0;
          meta_re    = 1'b1;
          meta_raddr = '0;
          state_d    = StEmitSt;
        end else begin
          wq_d       = wq_nxt;
          base_d     = base_nxt;
          meta_re    = 1'b1;
          meta_raddr = wq_nxt;
          state_d    = StChkSt;
        end
      end
      StEmitSt: begin
        st_re      = 1'b1;
        meta_we    = 1'b1;
        meta_wdata = {meta_fill - FillW'(1), head_inc};
        state_d    = StEmitOut;
      end
      StEmitOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = wq_last;
          out_data_d  = {{OutPadW{1'b0}}, ovf_q, qidx_ext[QIdxOutW-1:0], st_rdata};
          if (wq_last) begin
            cur_win_d = cur_win_q + WinW'(1);
            wq_d      = '0;
            base_d    = '0;
            state_d   = StIdle;
          end else begin
            wq_d       = wq_nxt;
            base_d     = base_nxt;
            meta_re    = 1'b1;
            meta_raddr = wq_nxt;
            state_d    = StEmitSt;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      wq_q        <= '0;
      base_q      <= '0;
      cur_win_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wq_q        <= wq_d;
      base_q      <= base_d;
      cur_win_q   <= cur_win_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pq_q        <= pq_d;
    push_base_q <= push_base_d;
    entry_q     <= entry_d;
    out_last_q  <= out_last_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  // A dispatched head was checked against the current window during the check walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmitOut) |-> (st_rdata.window == cur_win_q))
    else $error("dispatched head does not belong to the current window");

  // The dispatch walk only pops queues that the check walk found non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmitSt) |-> (meta_fill != '0))
    else $error("dispatch walk reached an empty queue");

  // A new output item only appears from the dispatch walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StEmitOut))
    else $error("output item loaded outside the dispatch walk");

  // The window counter moves only when the last item of a window is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_win_q != $past(cur_win_q)) |-> (($past(state_q) == StEmitOut) && out_last_q))
    else $error("window counter advanced without a completed dispatch");
`endif

endmodule
